// ----- sv/arqrw_pkg.sv -----
// Shared types and constants for the ARQ receive reorder window.
// Word layouts, slot and link codes, controller/datapath interface structs.
// No dependencies.
package arqrw_pkg;

    // Input word fields (s_tdata), lowest bit first
    localparam int SEQ_ID_W   = 11;
    localparam int META_W     = 16;
    localparam int REF_W      = 16;
    localparam int LEN_W      = 9;
    localparam int LENM1_W    = 8;
    localparam int ACTION_W   = 2;
    localparam int LINK_W     = 2;

    localparam int META_LSB = SEQ_ID_W;
    localparam int REF_LSB  = META_LSB + META_W;
    localparam int LEN_LSB  = REF_LSB + REF_W;
    localparam int FIELDS_W = LEN_LSB + LEN_W;
    localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
    localparam int PAD_W    = TDATA_W - FIELDS_W;
    localparam int M_TUSER_W = 1 + LINK_W;

    // Actions
    localparam logic [ACTION_W-1:0] ACT_DATA        = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FRAMING_ERR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESET_WIN   = 2'd2;

    // Slot status
    localparam logic [1:0] SLOT_IDLE   = 2'd0;
    localparam logic [1:0] SLOT_ACKED  = 2'd1;
    localparam logic [1:0] SLOT_NACKED = 2'd2;

    // Link frame types
    localparam logic [LINK_W-1:0] LINK_ACK_ALL = 2'd0;
    localparam logic [LINK_W-1:0] LINK_ACK_ONE = 2'd1;
    localparam logic [LINK_W-1:0] LINK_NACK_ID = 2'd2;
    localparam logic [LINK_W-1:0] LINK_NACK_FE = 2'd3;

    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_LINK    = 1'b1;

    // Result selects for the output register
    localparam logic [2:0] EM_DELIVER_IN  = 3'd0;
    localparam logic [2:0] EM_DELIVER_RAM = 3'd1;
    localparam logic [2:0] EM_ACK_ALL     = 3'd2;
    localparam logic [2:0] EM_ACK_ONE     = 3'd3;
    localparam logic [2:0] EM_NACK_ID     = 3'd4;
    localparam logic [2:0] EM_NACK_GAP    = 3'd5;
    localparam logic [2:0] EM_NACK_FE     = 3'd6;

    typedef struct packed {
        logic       load;
        logic       clear_win;
        logic       deliver_in;
        logic       start_gap;
        logic       gap_step;
        logic       store;
        logic       drain_rd;
        logic       drain_step;
        logic       emit;
        logic       last;
        logic [2:0] emit_sel;
    } cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] act;
        logic                is_next;
        logic                is_old;
        logic                is_beyond;
        logic                ms_match;
        logic                gap_done;
        logic                gap_idle;
        logic                drain_ack;
        logic                drain_room;
        logic                out_free;
    } sts_t;

    // Slot count: window rounded down to a power of two (at most 32), capped at half the id space
    function automatic int win_size(input int rx, input int idb);
        int p2;
        int half;
        p2 = (rx >= 32) ? 32 : (rx >= 16) ? 16 : (rx >= 8) ? 8 :
             (rx >= 4) ? 4 : (rx >= 2) ? 2 : 1;
        half = 1 << (idb - 1);
        return (p2 < half) ? p2 : half;
    endfunction

endpackage

// ----- sv/arqrw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module arqrw_ram #(
    parameter int WIDTH  = 40,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/arqrw_ctrl.sv -----
// Sequencer for the reorder window: classifies a word, walks gaps and drains.
// Depends on arqrw_pkg.
module arqrw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  arqrw_pkg::sts_t   sts,
    output arqrw_pkg::cmd_t   cmd
);
    import arqrw_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_CLASS     = 3'd1;
    localparam logic [2:0] S_ACKALL    = 3'd2;
    localparam logic [2:0] S_DRAIN_RD  = 3'd3;
    localparam logic [2:0] S_DRAIN_OUT = 3'd4;
    localparam logic [2:0] S_GAP       = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CLASS;
                end
            end
            S_CLASS:
            begin
                case (sts.act)
                    ACT_RESET_WIN:
                    begin
                        cmd.clear_win = 1'b1;
                        state_next    = S_IDLE;
                    end
                    ACT_FRAMING_ERR:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.emit     = 1'b1;
                            cmd.last     = 1'b1;
                            cmd.emit_sel = EM_NACK_FE;
                            state_next   = S_IDLE;
                        end
                    end
                    ACT_DATA:
                    begin
                        if (sts.is_next)
                        begin
                            if (sts.out_free)
                            begin
                                cmd.emit       = 1'b1;
                                cmd.emit_sel   = EM_DELIVER_IN;
                                cmd.deliver_in = 1'b1;
                                state_next     = sts.ms_match ? S_ACKALL : S_DRAIN_RD;
                            end
                        end
                        else if (sts.is_old)
                        begin
                            if (sts.out_free)
                            begin
                                cmd.emit     = 1'b1;
                                cmd.last     = 1'b1;
                                cmd.emit_sel = EM_ACK_ALL;
                                state_next   = S_IDLE;
                            end
                        end
                        else if (sts.is_beyond)
                        begin
                            if (sts.out_free)
                            begin
                                cmd.emit     = 1'b1;
                                cmd.last     = 1'b1;
                                cmd.emit_sel = EM_NACK_ID;
                                state_next   = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.start_gap = 1'b1;
                            state_next    = S_GAP;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_ACKALL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.last     = 1'b1;
                    cmd.emit_sel = EM_ACK_ALL;
                    state_next   = S_IDLE;
                end
            end
            S_DRAIN_RD:
            begin
                if (sts.drain_ack && sts.drain_room)
                begin
                    cmd.drain_rd = 1'b1;
                    state_next   = S_DRAIN_OUT;
                end
                else
                begin
                    state_next = S_ACKALL;
                end
            end
            S_DRAIN_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_sel   = EM_DELIVER_RAM;
                    cmd.drain_step = 1'b1;
                    state_next     = S_DRAIN_RD;
                end
            end
            S_GAP:
            begin
                if (sts.gap_done)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.last     = 1'b1;
                        cmd.emit_sel = EM_ACK_ONE;
                        cmd.store    = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else if (sts.gap_idle)
                begin
                    // idle gap slot: mark nacked and report it
                    if (sts.out_free)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = EM_NACK_GAP;
                        cmd.gap_step = 1'b1;
                    end
                end
                else
                begin
                    cmd.gap_step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/arqrw_dp.sv -----
// Datapath of the reorder window: id counters, slot status, slot RAM, result register.
// Depends on arqrw_pkg and arqrw_ram.
module arqrw_dp #(
    parameter int RX_WINDOW   = 32,
    parameter int ID_BITS     = 11,
    parameter int PAYLOAD_MAX = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [arqrw_pkg::TDATA_W-1:0]       s_tdata,
    input  logic [arqrw_pkg::ACTION_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [arqrw_pkg::TDATA_W-1:0]       m_tdata,
    output logic [arqrw_pkg::M_TUSER_W-1:0]     m_tuser,
    output logic                                m_tlast,
    input  arqrw_pkg::cmd_t                     cmd,
    output arqrw_pkg::sts_t                     sts
);
    import arqrw_pkg::*;

    localparam int WIN    = win_size(RX_WINDOW, ID_BITS);
    localparam int IDX_W  = (WIN > 1) ? $clog2(WIN) : 1;
    localparam int CNT_W  = IDX_W + 1;
    localparam int SLOT_W = META_W + REF_W + LENM1_W;
    localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(WIN - 1);

    // captured input word
    logic [ACTION_W-1:0] act_reg;
    logic [ID_BITS-1:0]  id_reg;
    logic [META_W-1:0]   meta_reg;
    logic [REF_W-1:0]    ref_reg;
    logic [LEN_W-1:0]    len_reg;

    logic [ID_BITS-1:0]  ne_reg;
    logic [ID_BITS-1:0]  ne_next;
    logic [ID_BITS-1:0]  ms_reg;
    logic [ID_BITS-1:0]  ms_next;
    logic [ID_BITS-1:0]  g_reg;     // gap walk / drain pointer
    logic [ID_BITS-1:0]  g_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;

    logic [1:0]          slot_st_reg [WIN];

    logic [LEN_W-1:0]    in_len;
    logic [LEN_W-1:0]    in_len_clamped;
    logic [IDX_W-1:0]    id_idx;
    logic [IDX_W-1:0]    g_idx;
    logic [1:0]          st_g;
    logic [ID_BITS-1:0]  ne_inc;
    logic [ID_BITS-1:0]  g_inc;
    logic [ID_BITS-1:0]  d_id_ne;
    logic [ID_BITS-1:0]  d_end_id;
    logic [ID_BITS-1:0]  d_id_ms;
    logic                id_ahead_ms;

    logic                st_we;
    logic [IDX_W-1:0]    st_wa;
    logic [1:0]          st_wd;

    logic [SLOT_W-1:0]   ram_wdata;
    logic [SLOT_W-1:0]   ram_rdata;
    logic [META_W-1:0]   ram_meta;
    logic [REF_W-1:0]    ram_ref;
    logic [LENM1_W-1:0]  ram_lenm1;

    // result register
    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    logic                   kind_reg;
    logic                   kind_next;
    logic [LINK_W-1:0]      link_reg;
    logic [LINK_W-1:0]      link_next;
    logic [SEQ_ID_W-1:0]    oid_reg;
    logic [SEQ_ID_W-1:0]    oid_next;
    logic [META_W-1:0]      ometa_reg;
    logic [META_W-1:0]      ometa_next;
    logic [REF_W-1:0]       oref_reg;
    logic [REF_W-1:0]       oref_next;
    logic [LEN_W-1:0]       olen_reg;
    logic [LEN_W-1:0]       olen_next;
    logic                   olast_reg;

    // length clamp to 1..PAYLOAD_MAX
    assign in_len = s_tdata[LEN_LSB +: LEN_W];
    always_comb
    begin
        in_len_clamped = in_len;
        if (in_len == '0)
        begin
            in_len_clamped = LEN_W'(1);
        end
        else if (in_len > LEN_W'(PAYLOAD_MAX))
        begin
            in_len_clamped = LEN_W'(PAYLOAD_MAX);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= s_tuser;
            id_reg   <= ID_BITS'(s_tdata[SEQ_ID_W-1:0]);
            meta_reg <= s_tdata[META_LSB +: META_W];
            ref_reg  <= s_tdata[REF_LSB +: REF_W];
            len_reg  <= in_len_clamped;
        end
    end

    assign id_idx = id_reg[IDX_W-1:0] & IDX_MASK;
    assign g_idx  = g_reg[IDX_W-1:0] & IDX_MASK;
    assign st_g   = slot_st_reg[g_idx];
    assign ne_inc = ne_reg + ID_BITS'(1);
    assign g_inc  = g_reg + ID_BITS'(1);

    // modular distances: sign bit marks a negative distance
    assign d_id_ne     = id_reg - ne_reg;
    assign d_end_id    = ne_reg + ID_BITS'(WIN) - id_reg;
    assign d_id_ms     = id_reg - ms_reg;
    assign id_ahead_ms = (d_id_ms != '0) && !d_id_ms[ID_BITS-1];

    always_comb
    begin
        sts.act        = act_reg;
        sts.is_next    = (id_reg == ne_reg);
        sts.is_old     = d_id_ne[ID_BITS-1];
        sts.is_beyond  = (d_end_id == '0) || d_end_id[ID_BITS-1];
        sts.ms_match   = (ms_reg == id_reg);
        sts.gap_done   = (g_reg == id_reg);
        sts.gap_idle   = (st_g == SLOT_IDLE);
        sts.drain_ack  = (st_g == SLOT_ACKED);
        sts.drain_room = (cnt_reg < CNT_W'(WIN - 1));
        sts.out_free   = !m_tvalid_reg || m_tready;
    end

    // id counters
    always_comb
    begin
        ne_next  = ne_reg;
        ms_next  = ms_reg;
        g_next   = g_reg;
        cnt_next = cnt_reg;
        if (cmd.clear_win)
        begin
            ne_next = '0;
            ms_next = '0;
        end
        if (cmd.deliver_in)
        begin
            ne_next  = ne_inc;
            g_next   = ne_inc;
            cnt_next = '0;
            if (ms_reg == id_reg)
            begin
                ms_next = ne_inc;
            end
        end
        if (cmd.start_gap)
        begin
            g_next = ne_reg;
            if (id_ahead_ms)
            begin
                ms_next = id_reg;
            end
        end
        if (cmd.gap_step)
        begin
            g_next = g_inc;
        end
        if (cmd.drain_step)
        begin
            ne_next  = ne_inc;
            g_next   = g_inc;
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ne_reg  <= '0;
            ms_reg  <= '0;
            g_reg   <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            ne_reg  <= ne_next;
            ms_reg  <= ms_next;
            g_reg   <= g_next;
            cnt_reg <= cnt_next;
        end
    end

    // slot status write port, one op per cycle
    always_comb
    begin
        st_we = 1'b0;
        st_wa = id_idx;
        st_wd = SLOT_IDLE;
        if (cmd.deliver_in)
        begin
            st_we = 1'b1;
        end
        else if (cmd.store)
        begin
            st_we = 1'b1;
            st_wd = SLOT_ACKED;
        end
        else if (cmd.gap_step)
        begin
            st_we = (st_g == SLOT_IDLE);
            st_wa = g_idx;
            st_wd = SLOT_NACKED;
        end
        else if (cmd.drain_step)
        begin
            st_we = 1'b1;
            st_wa = g_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                slot_st_reg[i] <= SLOT_IDLE;
            end
        end
        else if (cmd.clear_win)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                slot_st_reg[i] <= SLOT_IDLE;
            end
        end
        else if (st_we)
        begin
            slot_st_reg[st_wa] <= st_wd;
        end
    end

    assign ram_wdata = {meta_reg, ref_reg, LENM1_W'(len_reg - LEN_W'(1))};

    arqrw_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (WIN)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (cmd.store),
        .wr_addr (id_idx),
        .wr_data (ram_wdata),
        .rd_en   (cmd.drain_rd),
        .rd_addr (g_idx),
        .rd_data (ram_rdata)
    );

    assign {ram_meta, ram_ref, ram_lenm1} = ram_rdata;

    // result select
    always_comb
    begin
        kind_next  = KIND_LINK;
        link_next  = LINK_ACK_ALL;
        oid_next   = SEQ_ID_W'(id_reg);
        ometa_next = '0;
        oref_next  = '0;
        olen_next  = '0;
        case (cmd.emit_sel)
            EM_DELIVER_IN:
            begin
                kind_next  = KIND_DELIVER;
                ometa_next = meta_reg;
                oref_next  = ref_reg;
                olen_next  = len_reg;
            end
            EM_DELIVER_RAM:
            begin
                kind_next  = KIND_DELIVER;
                oid_next   = SEQ_ID_W'(ne_reg);
                ometa_next = ram_meta;
                oref_next  = ram_ref;
                olen_next  = LEN_W'(ram_lenm1) + LEN_W'(1);
            end
            EM_ACK_ALL:
            begin
                oid_next = SEQ_ID_W'(ne_reg - ID_BITS'(1));
            end
            EM_ACK_ONE:
            begin
                link_next = LINK_ACK_ONE;
            end
            EM_NACK_ID:
            begin
                link_next = LINK_NACK_ID;
            end
            EM_NACK_GAP:
            begin
                link_next = LINK_NACK_ID;
                oid_next  = SEQ_ID_W'(g_reg);
            end
            EM_NACK_FE:
            begin
                link_next = LINK_NACK_FE;
                oid_next  = SEQ_ID_W'(ne_reg);
            end
            default:
            begin
                link_next = LINK_ACK_ALL;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.emit)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            kind_reg  <= kind_next;
            link_reg  <= link_next;
            oid_reg   <= oid_next;
            ometa_reg <= ometa_next;
            oref_reg  <= oref_next;
            olen_reg  <= olen_next;
            olast_reg <= cmd.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, olen_reg, oref_reg, ometa_reg, oid_reg};
    assign m_tuser  = {link_reg, kind_reg};
    assign m_tlast  = olast_reg;

endmodule

// ----- sv/arq_receive_reorder_window.sv -----
// ARQ receive reorder window, top level. Per word: capture (S_IDLE), then classify (S_CLASS);
// the first result is loaded from S_CLASS, or from S_GAP when the frame is stored.
// Gap walk: one slot at a time between next expected id and the frame id (up to WIN-1).
// In-order drain: per stored frame a slot RAM read, then the result, up to WIN-1 frames.
// One word in flight at a time; s_tready returns the cycle after the last result is loaded.
// Async active-low reset clears counters and slot status at once; slot RAM needs no clear.
module arq_receive_reorder_window #(
    parameter int RX_WINDOW   = 32,
    parameter int ID_BITS     = 11,
    parameter int PAYLOAD_MAX = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: seq_id[10:0], meta_word[26:11], payload_ref[42:27],
    //          payload_len[51:43], zero pad[55:52]
    input  logic [arqrw_pkg::TDATA_W-1:0]    s_tdata,
    // s_tuser: action[1:0]
    input  logic [arqrw_pkg::ACTION_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: out_seq_id[10:0], out_meta[26:11], out_payload_ref[42:27],
    //          out_len[51:43], zero pad[55:52]
    output logic [arqrw_pkg::TDATA_W-1:0]    m_tdata,
    // m_tuser: result_kind[0], link_type[2:1]
    output logic [arqrw_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                             m_tlast
);
    import arqrw_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Controller: decides the path of each word and paces results against
    // the output register (out_free).
    arqrw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: next expected / max seen ids, slot status flops, slot RAM for
    // stored descriptors, and the result register that drives the m_ side.
    arqrw_dp #(
        .RX_WINDOW   (RX_WINDOW),
        .ID_BITS     (ID_BITS),
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .sts      (sts)
    );

`ifndef SYNTHESIS
    // a result is loaded only when the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
    else $error("result loaded over a pending word");

    // at most one state-changing datapath op per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.clear_win, cmd.deliver_in, cmd.start_gap,
                  cmd.gap_step, cmd.store, cmd.drain_rd, cmd.drain_step}))
    else $error("conflicting datapath ops");

    // after the final result of a word the block takes input again
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && cmd.last |=> s_tready)
    else $error("input not reopened after last result");

    // one word in flight: no accept directly after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("second word taken while first in progress");
`endif

endmodule

// ----- tb/arq_receive_reorder_window_tb.sv -----
// Self-checking testbench for the ARQ receive reorder window.
// Drives descriptor words on the slave stream, predicts every result word and checks it.
// Depends on arqrw_pkg and arq_receive_reorder_window.
`timescale 1ns / 1ps

module arq_receive_reorder_window_tb;

    import arqrw_pkg::*;

    // Slot count for RX_WINDOW = 32 and ID_BITS = 11 (power of two, below half the id space)
    localparam int SLOTS        = 32;
    localparam int ID_MASK      = 2047;
    localparam int LEN_CAP      = 256;
    localparam int ITEM_GOAL    = 330;
    localparam int STALL_CYCLES = 600;
    // Worst case after the last result: a full drain (slot RAM read, then result, per slot) plus margin
    localparam int SETTLE_CYCLES = 4 * SLOTS + 20;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // One input word plus, for hand-checked rows, the link word it must end with
    typedef struct packed {
        logic [ACTION_W-1:0]   act;
        logic [SEQ_ID_W-1:0]   fid;
        logic [META_W-1:0]     meta;
        logic [REF_W-1:0]      bref;
        logic [LEN_W-1:0]      len;
        logic                  typed;
        logic [LINK_W-1:0]     exp_link;
        logic [SEQ_ID_W-1:0]   exp_id;
    } word_t;

    // One result word as it should leave the block
    typedef struct {
        logic                  kind;
        logic [LINK_W-1:0]     link;
        logic [SEQ_ID_W-1:0]   fid;
        logic [META_W-1:0]     meta;
        logic [REF_W-1:0]      bref;
        logic [LEN_W-1:0]      len;
        logic                  last;
    } reply_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata = '0;
    logic [ACTION_W-1:0]    s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_W-1:0]     m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   m_tlast;

    // Window state as the block should hold it
    logic [SEQ_ID_W-1:0]    next_id = '0;
    logic [SEQ_ID_W-1:0]    far_id = '0;
    logic [1:0]             slot_st [SLOTS];
    logic [META_W-1:0]      slot_md [SLOTS];
    logic [REF_W-1:0]       slot_bf [SLOTS];
    logic [LENM1_W-1:0]     slot_lm1 [SLOTS];

    reply_t                 pending_replies [$];
    int                     words_sent = 0;
    int                     mismatches = 0;
    bit                     send_quiet = 1'b0;
    bit                     recv_quiet = 1'b0;
    word_t                  directed_rows [20];

    always #5 clk = ~clk;

    arq_receive_reorder_window u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Wait before the next word: mostly a random gap, with runs of back-to-back words
    function automatic int draw_gap(inout bit quiet);
        if ($urandom_range(0, 15) == 0)
            quiet = ~quiet;
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    // Signed distance a - b over the modular id space
    function automatic int id_gap(input logic [SEQ_ID_W-1:0] a, input logic [SEQ_ID_W-1:0] b);
        logic [SEQ_ID_W-1:0] d;
        d = a - b;
        return (int'(d) > ID_MASK / 2) ? int'(d) - (ID_MASK + 1) : int'(d);
    endfunction

    function automatic void push_reply(input logic kind, input logic [LINK_W-1:0] link,
                                       input logic [SEQ_ID_W-1:0] fid,
                                       input logic [META_W-1:0] meta,
                                       input logic [REF_W-1:0] bref,
                                       input logic [LEN_W-1:0] len);
        reply_t r;
        r.kind = kind;
        r.link = link;
        r.fid  = fid;
        r.meta = meta;
        r.bref = bref;
        r.len  = len;
        r.last = 1'b0;
        pending_replies.push_back(r);
    endfunction

    function automatic void push_link(input logic [LINK_W-1:0] link,
                                      input logic [SEQ_ID_W-1:0] fid);
        push_reply(KIND_LINK, link, fid, '0, '0, '0);
    endfunction

    // Updates the window state for one accepted word and queues the words it releases
    function automatic void forecast_replies(input word_t w);
        logic [LEN_W-1:0]      len;
        logic [SEQ_ID_W-1:0]   walk;
        int                    steps;
        int                    i;
        int                    slot;
        len = (w.len == 0) ? LEN_W'(1) : (w.len > LEN_CAP) ? LEN_W'(LEN_CAP) : w.len;
        slot = int'(w.fid) % SLOTS;
        case (w.act)
            ACT_RESET_WIN:
            begin
                next_id = '0;
                far_id = '0;
                for (i = 0; i < SLOTS; i++)
                    slot_st[i] = SLOT_IDLE;
            end
            ACT_FRAMING_ERR:
                push_link(LINK_NACK_FE, next_id);
            ACT_DATA:
            begin
                if (w.fid == next_id)
                begin
                    // In order: deliver now, then drain stored successors
                    slot_st[slot] = SLOT_IDLE;
                    push_reply(KIND_DELIVER, LINK_ACK_ALL, w.fid, w.meta, w.bref, len);
                    next_id = next_id + 1'b1;
                    if (far_id == w.fid)
                    begin
                        far_id = next_id;
                        push_link(LINK_ACK_ALL, w.fid);
                    end
                    else
                    begin
                        steps = 0;
                        while (steps < SLOTS - 1 && slot_st[int'(next_id) % SLOTS] == SLOT_ACKED)
                        begin
                            i = int'(next_id) % SLOTS;
                            slot_st[i] = SLOT_IDLE;
                            push_reply(KIND_DELIVER, LINK_ACK_ALL, next_id, slot_md[i],
                                       slot_bf[i], LEN_W'(slot_lm1[i]) + 1'b1);
                            next_id = next_id + 1'b1;
                            steps++;
                        end
                        push_link(LINK_ACK_ALL, next_id - 1'b1);
                    end
                end
                else if (id_gap(w.fid, next_id) < 0)
                    push_link(LINK_ACK_ALL, next_id - 1'b1);
                else if (id_gap(next_id + SEQ_ID_W'(SLOTS), w.fid) <= 0)
                    push_link(LINK_NACK_ID, w.fid);
                else
                begin
                    // Ahead of next expected: nack fresh gaps, store, ack this one
                    if (id_gap(w.fid, far_id) > 0)
                        far_id = w.fid;
                    walk = next_id;
                    steps = 0;
                    while (steps < SLOTS && walk != w.fid)
                    begin
                        i = int'(walk) % SLOTS;
                        if (slot_st[i] == SLOT_IDLE)
                        begin
                            slot_st[i] = SLOT_NACKED;
                            push_link(LINK_NACK_ID, walk);
                        end
                        walk = walk + 1'b1;
                        steps++;
                    end
                    slot_st[slot]  = SLOT_ACKED;
                    slot_lm1[slot] = LENM1_W'(len - 1'b1);
                    slot_md[slot]  = w.meta;
                    slot_bf[slot]  = w.bref;
                    push_link(LINK_ACK_ONE, w.fid);
                end
            end
            default:
                ;
        endcase
    endfunction

    function automatic void match_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_reply(input logic [TDATA_W-1:0] data,
                                        input logic [M_TUSER_W-1:0] user, input logic tl);
        reply_t want;
        if (pending_replies.size() == 0)
        begin
            $error("unexpected result word: tuser=0x%0h tdata=0x%0h tlast=%0b", user, data, tl);
            mismatches++;
            return;
        end
        want = pending_replies.pop_front();
        match_field("result_kind", 16'(want.kind), 16'(user[0]));
        match_field("link_type", 16'(want.link), 16'(user[2:1]));
        match_field("out_seq_id", 16'(want.fid), 16'(data[SEQ_ID_W-1:0]));
        match_field("out_meta", want.meta, data[META_LSB +: META_W]);
        match_field("out_payload_ref", want.bref, data[REF_LSB +: REF_W]);
        match_field("out_len", 16'(want.len), 16'(data[LEN_LSB +: LEN_W]));
        match_field("last", 16'(want.last), 16'(tl));
    endfunction

    // Offer one word, wait for the handshake, predict, then hold off for the drawn gap.
    // tvalid stays high when the gap is zero so the next word follows at once.
    task automatic send_word(input word_t w);
        int     gap;
        int     n_before;
        reply_t tail;
        s_tuser  <= w.act;
        s_tdata  <= {{PAD_W{1'b0}}, w.len, w.bref, w.meta, w.fid};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        n_before = pending_replies.size();
        forecast_replies(w);
        if (pending_replies.size() > n_before)
        begin
            tail = pending_replies[pending_replies.size() - 1];
            tail.last = 1'b1;
            if (w.typed)
            begin
                tail.kind = KIND_LINK;
                tail.link = w.exp_link;
                tail.fid  = w.exp_id;
                tail.meta = '0;
                tail.bref = '0;
                tail.len  = '0;
            end
            pending_replies[pending_replies.size() - 1] = tail;
        end
        if (w.act != ACT_UNUSED)
            words_sent++;
        gap = draw_gap(send_quiet);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Lengths lean to the legal range; zero and oversize still show up
    function automatic logic [LEN_W-1:0] pick_len();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return LEN_W'($urandom_range(LEN_CAP + 1, 511));
            2:       return LEN_W'(LEN_CAP);
            3:       return LEN_W'(1);
            default: return LEN_W'($urandom_range(1, LEN_CAP));
        endcase
    endfunction

    function automatic word_t data_word(input logic [SEQ_ID_W-1:0] fid);
        word_t w;
        w.act      = ACT_DATA;
        w.fid      = fid;
        w.meta     = META_W'($urandom());
        w.bref     = REF_W'($urandom());
        w.len      = pick_len();
        w.typed    = 1'b0;
        w.exp_link = LINK_ACK_ALL;
        w.exp_id   = '0;
        return w;
    endfunction

    // A run of frames next_id .. next_id+span-1 in shuffled order. Full-window runs
    // keep the in-order frame for the end so it drains every stored slot. Some runs
    // lose the in-order frame, leaving stored frames for the next run to overlap.
    task automatic run_window_burst();
        int                    span;
        int                    order [$];
        int                    i;
        int                    pick;
        int                    tmp;
        bit                    drop_head;
        logic [SEQ_ID_W-1:0]   base;
        base = next_id;
        span = ($urandom_range(0, 5) == 0) ? SLOTS : $urandom_range(1, 8);
        for (i = 1; i < span; i++)
            order.push_back(i);
        for (i = order.size() - 1; i > 0; i--)
        begin
            pick = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[pick];
            order[pick] = tmp;
        end
        if (span == SLOTS)
            order.push_back(0);
        else
            order.insert($urandom_range(0, order.size()), 0);
        drop_head = ($urandom_range(0, 4) == 0);
        for (i = 0; i < order.size(); i++)
        begin
            if (!(drop_head && order[i] == 0))
                send_word(data_word(base + SEQ_ID_W'(order[i])));
            if ($urandom_range(0, 9) == 0)
                send_word(data_word(base + SEQ_ID_W'(order[$urandom_range(0, i)])));
        end
    endtask

    // Stray words: any id, ids just old or just past the window, errors, resets, junk
    task automatic run_noise();
        word_t w;
        w = data_word(SEQ_ID_W'($urandom_range(0, ID_MASK)));
        case ($urandom_range(0, 9))
            0, 1, 2:
                ;
            3, 4:
                w.fid = next_id + SEQ_ID_W'($urandom_range(0, 40));
            5:
                w.fid = next_id - SEQ_ID_W'($urandom_range(1, 40));
            6, 7:
                w.act = ACT_FRAMING_ERR;
            8:
                w.act = ACT_UNUSED;
            default:
                w.act = ($urandom_range(0, 3) == 0) ? ACT_RESET_WIN : ACT_FRAMING_ERR;
        endcase
        send_word(w);
    endtask

    // Stimulus and end of run
    initial
    begin
        int i;
        for (i = 0; i < SLOTS; i++)
        begin
            slot_st[i]  = SLOT_IDLE;
            slot_md[i]  = '0;
            slot_bf[i]  = '0;
            slot_lm1[i] = '0;
        end
        // act, id, meta, payload ref, len, hand-checked, final link word type and id
        directed_rows = '{
            '{ACT_FRAMING_ERR, 11'd0,    16'h0000, 16'h0000, 9'd1,   1'b1, LINK_NACK_FE, 11'd0},
            '{ACT_DATA,        11'd0,    16'hFFFF, 16'h0000, 9'd1,   1'b1, LINK_ACK_ALL, 11'd0},
            '{ACT_DATA,        11'd0,    16'h0000, 16'hFFFF, 9'd256, 1'b1, LINK_ACK_ALL, 11'd0},
            '{ACT_DATA,        11'd33,   16'h1234, 16'h4321, 9'd64,  1'b1, LINK_NACK_ID, 11'd33},
            '{ACT_DATA,        11'd2047, 16'hFFFF, 16'hFFFF, 9'd256, 1'b1, LINK_ACK_ALL, 11'd0},
            '{ACT_DATA,        11'd32,   16'h0000, 16'hFFFF, 9'd256, 1'b1, LINK_ACK_ONE, 11'd32},
            '{ACT_DATA,        11'd5,    16'h00FF, 16'hFF00, 9'd0,   1'b1, LINK_ACK_ONE, 11'd5},
            '{ACT_DATA,        11'd2,    16'hFF00, 16'h00FF, 9'd511, 1'b1, LINK_ACK_ONE, 11'd2},
            '{ACT_DATA,        11'd3,    16'hA5A5, 16'h5A5A, 9'd300, 1'b1, LINK_ACK_ONE, 11'd3},
            '{ACT_DATA,        11'd1,    16'h1111, 16'h2222, 9'd17,  1'b0, LINK_ACK_ALL, 11'd0},
            '{ACT_UNUSED,      11'd2047, 16'hFFFF, 16'hFFFF, 9'd511, 1'b0, LINK_ACK_ALL, 11'd0},
            '{ACT_DATA,        11'd4,    16'h3333, 16'h4444, 9'd128, 1'b0, LINK_ACK_ALL, 11'd0},
            '{ACT_DATA,        11'd32,   16'hC3C3, 16'h3C3C, 9'd255, 1'b1, LINK_ACK_ONE, 11'd32},
            '{ACT_DATA,        11'd38,   16'h0001, 16'h8000, 9'd2,   1'b1, LINK_NACK_ID, 11'd38},
            '{ACT_DATA,        11'd37,   16'h7FFF, 16'h8001, 9'd200, 1'b0, LINK_ACK_ALL, 11'd0},
            '{ACT_FRAMING_ERR, 11'd1000, 16'h0000, 16'h0000, 9'd1,   1'b1, LINK_NACK_FE, 11'd6},
            '{ACT_RESET_WIN,   11'd0,    16'h0000, 16'h0000, 9'd1,   1'b0, LINK_ACK_ALL, 11'd0},
            '{ACT_FRAMING_ERR, 11'd0,    16'h0000, 16'h0000, 9'd1,   1'b1, LINK_NACK_FE, 11'd0},
            '{ACT_DATA,        11'd1,    16'hBEEF, 16'hCAFE, 9'd256, 1'b0, LINK_ACK_ALL, 11'd0},
            '{ACT_DATA,        11'd0,    16'h0F0F, 16'hF0F0, 9'd9,   1'b0, LINK_ACK_ALL, 11'd0}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: both sides of every id/meta/ref/len range, each action, each window case
        for (i = 0; i < $size(directed_rows); i++)
            send_word(directed_rows[i]);

        // Random: mostly window runs, the rest stray words
        while (words_sent < ITEM_GOAL)
        begin
            if ($urandom_range(0, 9) < 7)
                run_window_burst();
            else
                run_noise();
        end
        s_tvalid <= 1'b0;

        while (pending_replies.size() != 0)
            @(posedge clk);
        // Anything the block emits late still reaches the checker
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS arq_receive_reorder_window");
        else
            $display("FAIL arq_receive_reorder_window");
        $finish;
    end

    // Result side: random backpressure per word, plus one long hold-off that backs the
    // block up until it refuses input words
    initial
    begin
        int hold;
        int replies_seen;
        bit pressed;
        replies_seen = 0;
        pressed = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = draw_gap(recv_quiet);
            if (!pressed && replies_seen >= 60)
            begin
                pressed = 1'b1;
                hold = STALL_CYCLES;
            end
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (m_tvalid !== 1'b1)
                @(posedge clk);
            check_reply(m_tdata, m_tuser, m_tlast);
            replies_seen++;
        end
    end

    // Watchdog, several times the slowest legal run
    initial
    begin
        #12_000_000;
        $error("timeout: %0d result words still expected", pending_replies.size());
        $display("FAIL arq_receive_reorder_window");
        $finish;
    end

endmodule
